// ----- hdl/stt_pkg.sv -----
package stt_pkg;

  // Width of the running byte position.
  localparam int POS_BITS = 24;
  // Width of the reported start and length fields.
  localparam int FIELD_BITS = 24;
  // Pending token length counter width and its saturation value.
  localparam int LEN_BITS = (POS_BITS < FIELD_BITS) ? POS_BITS : FIELD_BITS;
  localparam logic [LEN_BITS-1:0] LEN_CAP = {LEN_BITS{1'b1}};

  // Result queue geometry.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // Input operation codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOT  = 1'b1;

  // Scanner modes.
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_MINUS = 3'd1;
  localparam logic [2:0] MODE_INT   = 3'd2;
  localparam logic [2:0] MODE_FRAC  = 3'd3;
  localparam logic [2:0] MODE_IDENT = 3'd4;

  // Token kinds.
  localparam logic [4:0] TK_EOF     = 5'd0;
  localparam logic [4:0] TK_COMMA   = 5'd1;
  localparam logic [4:0] TK_SEMI    = 5'd2;
  localparam logic [4:0] TK_LPAREN  = 5'd3;
  localparam logic [4:0] TK_RPAREN  = 5'd4;
  localparam logic [4:0] TK_LBRACE  = 5'd5;
  localparam logic [4:0] TK_RBRACE  = 5'd6;
  localparam logic [4:0] TK_ASSIGN  = 5'd7;
  localparam logic [4:0] TK_PLUS    = 5'd8;
  localparam logic [4:0] TK_STAR    = 5'd9;
  localparam logic [4:0] TK_SLASH   = 5'd10;
  localparam logic [4:0] TK_MINUS   = 5'd11;
  localparam logic [4:0] TK_INT     = 5'd12;
  localparam logic [4:0] TK_FLOAT   = 5'd13;
  localparam logic [4:0] TK_IDENT   = 5'd14;
  localparam logic [4:0] TK_KW_BASE = 5'd15;
  localparam logic [4:0] TK_UNKNOWN = 5'd21;

  // Characters with a role of their own.
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Keyword spelling, first character in the lowest byte.
  typedef logic [5:0][7:0] kw_chars_t;
  localparam int KW_COUNT = 6;
  localparam kw_chars_t KW_TEXT [KW_COUNT] = '{
    {8'h00, 8'h00, 8'h00, 8'h74, 8'h6E, 8'h69},  // int
    {8'h00, 8'h74, 8'h61, 8'h6F, 8'h6C, 8'h66},  // float
    {8'h00, 8'h00, 8'h00, 8'h72, 8'h6F, 8'h66},  // for
    {8'h00, 8'h65, 8'h6C, 8'h69, 8'h68, 8'h77},  // while
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h66, 8'h69},  // if
    {8'h6E, 8'h72, 8'h75, 8'h74, 8'h65, 8'h72}   // return
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd5, 3'd3, 3'd5, 3'd2, 3'd6};

  typedef struct packed {
    logic       opcode;
    logic [7:0] ch;
  } in_t;

  typedef struct packed {
    logic [4:0]            token_kind;
    logic [FIELD_BITS-1:0] token_start;
    logic [FIELD_BITS-1:0] token_length;
    logic                  last_of_run;
  } out_t;

  // Results of one scanned item, handed from the scanner to the queue.
  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } scan_res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h2C:   k = TK_COMMA;
      8'h3B:   k = TK_SEMI;
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h7B:   k = TK_LBRACE;
      8'h7D:   k = TK_RBRACE;
      8'h3D:   k = TK_ASSIGN;
      8'h2B:   k = TK_PLUS;
      8'h2A:   k = TK_STAR;
      8'h2F:   k = TK_SLASH;
      default: k = TK_EOF;
    endcase
    return k;
  endfunction

  // Identifier kind: a keyword kind when the stored prefix spells one.
  function automatic logic [4:0] ident_kind(input kw_chars_t kw, input logic [2:0] len);
    logic [4:0] kind;
    logic       found;
    logic       match;
    kind  = TK_IDENT;
    found = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      match = (len == KW_LEN[k]);
      for (int j = 0; j < 6; j++) begin
        if ((j < int'(KW_LEN[k])) && (kw[j] != KW_TEXT[k][j])) begin
          match = 1'b0;
        end
      end
      if (match && !found) begin
        found = 1'b1;
        kind  = TK_KW_BASE + 5'(k);
      end
    end
    return kind;
  endfunction

endpackage

// ----- hdl/stt_scan.sv -----
module stt_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  stt_pkg::in_t      item,
  output stt_pkg::scan_res_t res
);

  logic [2:0]                     mode_r, mode_nxt;
  logic [stt_pkg::POS_BITS-1:0]   pos_r, pos_nxt;
  logic [stt_pkg::POS_BITS-1:0]   pstart_r, pstart_nxt;
  logic [stt_pkg::LEN_BITS-1:0]   plen_r, plen_nxt;
  stt_pkg::kw_chars_t             kw_r, kw_nxt;
  logic [2:0]                     idlen_r, idlen_nxt;

  logic [7:0]                   c;
  logic                         eot;
  logic                         taken;
  logic [stt_pkg::LEN_BITS-1:0] grown;
  logic [4:0]                   pk;
  logic                         flush_vld;
  logic                         new_vld;
  stt_pkg::out_t                flush_tok;
  stt_pkg::out_t                new_tok;

  // Next scanner state and the tokens that this item finishes.
  always_comb begin
    c     = item.ch;
    eot   = (item.opcode == stt_pkg::OP_EOT);
    pk    = stt_pkg::punct_kind(c);
    grown = (plen_r == stt_pkg::LEN_CAP) ? plen_r : plen_r + 1'b1;

    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    pstart_nxt = pstart_r;
    plen_nxt   = plen_r;
    kw_nxt     = kw_r;
    idlen_nxt  = idlen_r;
    taken      = 1'b0;
    new_vld    = 1'b0;

    // Pending token as it stands before this item.
    flush_tok.token_start  = stt_pkg::FIELD_BITS'(pstart_r);
    flush_tok.token_length = stt_pkg::FIELD_BITS'(plen_r);
    flush_tok.last_of_run  = 1'b0;
    case (mode_r)
      stt_pkg::MODE_MINUS: flush_tok.token_kind = stt_pkg::TK_MINUS;
      stt_pkg::MODE_INT:   flush_tok.token_kind = stt_pkg::TK_INT;
      stt_pkg::MODE_FRAC:  flush_tok.token_kind = stt_pkg::TK_FLOAT;
      stt_pkg::MODE_IDENT: flush_tok.token_kind = stt_pkg::ident_kind(kw_r, idlen_r);
      default:             flush_tok.token_kind = stt_pkg::TK_EOF;
    endcase

    new_tok.token_kind   = stt_pkg::TK_EOF;
    new_tok.token_start  = stt_pkg::FIELD_BITS'(pos_r);
    new_tok.token_length = stt_pkg::FIELD_BITS'(1);
    new_tok.last_of_run  = 1'b0;

    if (eot) begin
      // End of text: flush, report end of file and return to reset state.
      new_vld              = 1'b1;
      new_tok.token_length = '0;
      mode_nxt   = stt_pkg::MODE_IDLE;
      pos_nxt    = '0;
      pstart_nxt = '0;
      plen_nxt   = '0;
      kw_nxt     = '0;
      idlen_nxt  = '0;
    end else begin
      // Extend the pending token when the byte fits it.
      if ((mode_r == stt_pkg::MODE_MINUS) && stt_pkg::is_digit(c)) begin
        mode_nxt = stt_pkg::MODE_INT;
        plen_nxt = grown;
        taken    = 1'b1;
      end else if ((mode_r == stt_pkg::MODE_INT) &&
                   (stt_pkg::is_digit(c) || (c == stt_pkg::CH_DOT))) begin
        if (c == stt_pkg::CH_DOT) begin
          mode_nxt = stt_pkg::MODE_FRAC;
        end
        plen_nxt = grown;
        taken    = 1'b1;
      end else if ((mode_r == stt_pkg::MODE_FRAC) && stt_pkg::is_digit(c)) begin
        plen_nxt = grown;
        taken    = 1'b1;
      end else if ((mode_r == stt_pkg::MODE_IDENT) && stt_pkg::is_word(c)) begin
        plen_nxt = grown;
        if (idlen_r < 3'd6) begin
          kw_nxt[idlen_r] = c;
        end
        if (idlen_r < 3'd7) begin
          idlen_nxt = idlen_r + 3'd1;
        end
        taken = 1'b1;
      end

      // Otherwise the pending token ends and the byte, unless it is a separator, starts something new.
      if (!taken) begin
        mode_nxt = stt_pkg::MODE_IDLE;
        if (stt_pkg::is_space(c)) begin
          new_vld = 1'b0;
        end else if (pk != stt_pkg::TK_EOF) begin
          new_vld            = 1'b1;
          new_tok.token_kind = pk;
        end else if ((c == stt_pkg::CH_MINUS) || stt_pkg::is_digit(c) ||
                     stt_pkg::is_word(c)) begin
          pstart_nxt = pos_r;
          plen_nxt   = stt_pkg::LEN_BITS'(1);
          kw_nxt     = '0;
          idlen_nxt  = '0;
          if (c == stt_pkg::CH_MINUS) begin
            mode_nxt = stt_pkg::MODE_MINUS;
          end else if (stt_pkg::is_digit(c)) begin
            mode_nxt = stt_pkg::MODE_INT;
          end else begin
            mode_nxt  = stt_pkg::MODE_IDENT;
            kw_nxt[0] = c;
            idlen_nxt = 3'd1;
          end
        end else begin
          new_vld            = 1'b1;
          new_tok.token_kind = stt_pkg::TK_UNKNOWN;
        end
      end
      pos_nxt = pos_r + 1'b1;
    end

    flush_vld = (mode_r != stt_pkg::MODE_IDLE) && (eot || !taken);
  end

  // Order the results and mark the final one of the run.
  always_comb begin
    res.count  = {1'b0, flush_vld} + {1'b0, new_vld};
    res.first  = flush_vld ? flush_tok : new_tok;
    res.second = new_tok;
    res.first.last_of_run  = (res.count == 2'd1);
    res.second.last_of_run = 1'b1;
  end

  // Scanner state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= stt_pkg::MODE_IDLE;
      pos_r    <= '0;
      pstart_r <= '0;
      plen_r   <= '0;
      kw_r     <= '0;
      idlen_r  <= '0;
    end else if (go) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      pstart_r <= pstart_nxt;
      plen_r   <= plen_nxt;
      kw_r     <= kw_nxt;
      idlen_r  <= idlen_nxt;
    end
  end

endmodule

// ----- hdl/stt_outq.sv -----
module stt_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_en,
  input  stt_pkg::scan_res_t push_res,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output stt_pkg::out_t      out_data
);

  stt_pkg::out_t                mem [stt_pkg::QDEPTH];
  logic [stt_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [stt_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [stt_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [1:0]                   n_push;
  logic                         pop;

  // Two free entries are needed to take any item's results.
  assign room      = (cnt_r <= stt_pkg::QCNT_W'(stt_pkg::QDEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign n_push    = push_en ? push_res.count : 2'd0;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + stt_pkg::QPTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + stt_pkg::QPTR_W'(pop);
    cnt_nxt    = cnt_r + stt_pkg::QCNT_W'(n_push) - stt_pkg::QCNT_W'(pop);
  end

  // Result storage, up to two writes per cycle.
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr_r] <= push_res.first;
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr_r + 1'b1] <= push_res.second;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- hdl/source_text_tokenizer.sv -----
// A text byte accepted into the input register is scanned and its results are written
// to the result queue when it has room for two; out_ shows them behind any older results.
// Throughput: one byte per cycle while the queue has room; a byte that ends a token and
// forms one of its own gives two results, which leave the single result port in turn.
// Reset (rst_n low, synchronous) empties the input register and the result queue
// and puts the scanner in its idle state at position zero.
module source_text_tokenizer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  stt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output stt_pkg::out_t out_data
);

  logic               in_vld_r, in_vld_nxt;
  stt_pkg::in_t       in_item_r;
  logic               room;
  logic               advance;
  logic               in_accept;
  stt_pkg::scan_res_t res;

  // The input register moves on whenever the queue can take two results.
  assign advance   = in_vld_r && room;
  assign in_stall  = in_vld_r && !room;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_accept) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item_r <= in_data;
    end
  end

  stt_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (advance),
    .item  (in_item_r),
    .res   (res)
  );

  stt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (advance),
    .push_res  (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/stt_checker.sv -----
module stt_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input stt_pkg::out_t out_data
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result payload changed while stalled");

  // End of file closes the run and has no length; other tokens have one.
  a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.token_kind == stt_pkg::TK_EOF) |->
      out_data.last_of_run && (out_data.token_length == '0))
    else $error("end of file token malformed");

  a_token_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.token_kind != stt_pkg::TK_EOF) |->
      (out_data.token_length != '0))
    else $error("token with zero length");

  // Input back-pressure only comes from a result queue without room for two results.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // Stall only rises right after an input transaction was taken.
  a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("input stall rose without a preceding transaction");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- dv/source_text_tokenizer_test.sv -----
module source_text_tokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;

  // Keyword kinds, in the order the keywords are numbered.
  localparam logic [4:0] KIND_KW_INT    = TK_KW_BASE + 5'd0;
  localparam logic [4:0] KIND_KW_FLOAT  = TK_KW_BASE + 5'd1;
  localparam logic [4:0] KIND_KW_FOR    = TK_KW_BASE + 5'd2;
  localparam logic [4:0] KIND_KW_WHILE  = TK_KW_BASE + 5'd3;
  localparam logic [4:0] KIND_KW_IF     = TK_KW_BASE + 5'd4;
  localparam logic [4:0] KIND_KW_RETURN = TK_KW_BASE + 5'd5;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  in_t   in_data;
  logic  out_valid;
  logic  out_stall;
  out_t  out_data;

  source_text_tokenizer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Scanner copy kept by the testbench.
  logic [2:0]            scan_state;
  logic [POS_BITS-1:0]   text_pos;
  logic [FIELD_BITS-1:0] tok_start;
  logic [LEN_BITS-1:0]   tok_len;
  logic [47:0]           word_prefix;
  logic [2:0]            word_len;

  out_t step_tokens[$];
  out_t expected_tokens[$];

  int   error_count;
  int   items_sent;
  int   text_bytes;
  int   eot_items;
  int   tokens_seen;
  bit   calm;
  int   stall_left;

  string keyword_words [6] = '{"int", "float", "for", "while", "if", "return"};
  string punct_chars = ",;(){}=+*/";

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Character classes of the source language.
  function automatic bit digit_char(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit word_char(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == CH_UNDER);
  endfunction

  function automatic bit space_char(input logic [7:0] c);
    return (c == " ") || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic [4:0] punct_code(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      ",":     k = TK_COMMA;
      ";":     k = TK_SEMI;
      "(":     k = TK_LPAREN;
      ")":     k = TK_RPAREN;
      "{":     k = TK_LBRACE;
      "}":     k = TK_RBRACE;
      "=":     k = TK_ASSIGN;
      "+":     k = TK_PLUS;
      "*":     k = TK_STAR;
      "/":     k = TK_SLASH;
      default: k = TK_EOF;
    endcase
    return k;
  endfunction

  // Kind of the identifier collected so far.
  function automatic logic [4:0] word_kind();
    if (word_len == 3'd3 && word_prefix == "int") return KIND_KW_INT;
    if (word_len == 3'd5 && word_prefix == "float") return KIND_KW_FLOAT;
    if (word_len == 3'd3 && word_prefix == "for") return KIND_KW_FOR;
    if (word_len == 3'd5 && word_prefix == "while") return KIND_KW_WHILE;
    if (word_len == 3'd2 && word_prefix == "if") return KIND_KW_IF;
    if (word_len == 3'd6 && word_prefix == "return") return KIND_KW_RETURN;
    return TK_IDENT;
  endfunction

  function automatic void emit_token(input logic [4:0] kind, input logic [FIELD_BITS-1:0] start,
                                     input logic [FIELD_BITS-1:0] len);
    out_t t;
    t.token_kind   = kind;
    t.token_start  = start;
    t.token_length = len;
    t.last_of_run  = 1'b0;
    step_tokens = {step_tokens, t};
  endfunction

  function automatic void clear_scanner();
    scan_state  = MODE_IDLE;
    text_pos    = '0;
    tok_start   = '0;
    tok_len     = '0;
    word_prefix = '0;
    word_len    = '0;
  endfunction

  // Report the token under construction, if any, and go idle.
  function automatic void flush_pending();
    case (scan_state)
      MODE_MINUS: emit_token(TK_MINUS, tok_start, FIELD_BITS'(tok_len));
      MODE_INT:   emit_token(TK_INT, tok_start, FIELD_BITS'(tok_len));
      MODE_FRAC:  emit_token(TK_FLOAT, tok_start, FIELD_BITS'(tok_len));
      MODE_IDENT: emit_token(word_kind(), tok_start, FIELD_BITS'(tok_len));
      default: ;
    endcase
    scan_state = MODE_IDLE;
  endfunction

  function automatic void open_token(input logic [2:0] mode);
    scan_state  = mode;
    tok_start   = FIELD_BITS'(text_pos);
    tok_len     = LEN_BITS'(1);
    word_prefix = '0;
    word_len    = '0;
  endfunction

  function automatic void extend_token();
    if (tok_len != LEN_CAP) tok_len = tok_len + 1'b1;
  endfunction

  // Only the first six letters are kept; the count stops at seven.
  function automatic void note_letter(input logic [7:0] c);
    if (word_len < 3'd6) word_prefix = {word_prefix[39:0], c};
    if (word_len < 3'd7) word_len = word_len + 1'b1;
  endfunction

  // Works out the tokens that one accepted transaction produces.
  function automatic void predict_tokens(input in_t item);
    logic [7:0] c;
    bit         taken;
    c     = item.ch;
    taken = 1'b0;
    step_tokens.delete();
    if (item.opcode == OP_EOT) begin
      flush_pending();
      emit_token(TK_EOF, FIELD_BITS'(text_pos), '0);
      clear_scanner();
    end else begin
      if (scan_state == MODE_MINUS && digit_char(c)) begin
        scan_state = MODE_INT;
        extend_token();
        taken = 1'b1;
      end else if (scan_state == MODE_INT && (digit_char(c) || c == CH_DOT)) begin
        if (c == CH_DOT) scan_state = MODE_FRAC;
        extend_token();
        taken = 1'b1;
      end else if (scan_state == MODE_FRAC && digit_char(c)) begin
        extend_token();
        taken = 1'b1;
      end else if (scan_state == MODE_IDENT && word_char(c)) begin
        extend_token();
        note_letter(c);
        taken = 1'b1;
      end
      if (!taken) begin
        flush_pending();
        if (space_char(c)) begin
          // Separators only end the pending token.
        end else if (punct_code(c) != TK_EOF) begin
          emit_token(punct_code(c), FIELD_BITS'(text_pos), FIELD_BITS'(1));
        end else if (c == CH_MINUS) begin
          open_token(MODE_MINUS);
        end else if (digit_char(c)) begin
          open_token(MODE_INT);
        end else if (word_char(c)) begin
          open_token(MODE_IDENT);
          note_letter(c);
        end else begin
          emit_token(TK_UNKNOWN, FIELD_BITS'(text_pos), FIELD_BITS'(1));
        end
      end
      text_pos = text_pos + 1'b1;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
    expected_tokens = {expected_tokens, step_tokens};
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 40) $display("ERROR at %0t ns: %s", $time, what);
  endtask

  // Compare one accepted result transaction with the oldest expectation.
  task automatic check_token(input out_t got);
    out_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("unexpected token kind %0d start %0d length %0d",
                                got.token_kind, got.token_start, got.token_length));
    end else begin
      want = expected_tokens.pop_front();
      if (got.token_kind !== want.token_kind)
        report_mismatch($sformatf("token %0d kind %0d, expected %0d",
                                  tokens_seen, got.token_kind, want.token_kind));
      if (got.token_start !== want.token_start)
        report_mismatch($sformatf("token %0d start %0d, expected %0d",
                                  tokens_seen, got.token_start, want.token_start));
      if (got.token_length !== want.token_length)
        report_mismatch($sformatf("token %0d length %0d, expected %0d",
                                  tokens_seen, got.token_length, want.token_length));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch($sformatf("token %0d last flag %0b, expected %0b",
                                  tokens_seen, got.last_of_run, want.last_of_run));
    end
    tokens_seen++;
  endtask

  // Result side: values are stable at the falling edge before the accepting edge.
  always @(negedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) check_token(out_data);
  end

  function automatic int pick_stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(20, 60);
  endfunction

  // Result-side back-pressure.
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left = pick_stall_len();
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one transaction and hold it until it is taken.
  task automatic send_item(input logic op, input logic [7:0] c);
    int gap;
    bit accepted;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data      <= '{opcode: op, ch: c};
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk);
      accepted = (in_stall === 1'b0);
      if (accepted) predict_tokens(in_data);
      @(posedge clk);
    end
    items_sent++;
    if (op == OP_EOT) eot_items++;
    else text_bytes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_BYTE, s[i]);
  endtask

  task automatic send_eot();
    send_item(OP_EOT, 8'($urandom_range(0, 255)));
  endtask

  // Withdraw the input and wait until every predicted token has arrived.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] random_space();
    if ($urandom_range(0, 1) == 0) return " ";
    return 8'($urandom_range(9, 13));
  endfunction

  // A byte that starts no token and is no separator.
  function automatic logic [7:0] random_stray();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) return CH_DOT;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (digit_char(c) || word_char(c) || space_char(c) ||
               punct_code(c) != TK_EOF || c == CH_MINUS);
    return c;
  endfunction

  task automatic send_number();
    int ndig;
    if ($urandom_range(0, 3) == 0) send_item(OP_BYTE, CH_MINUS);
    ndig = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 5);
    repeat (ndig) send_item(OP_BYTE, 8'("0" + $urandom_range(0, 9)));
    if ($urandom_range(0, 1) == 0) begin
      send_item(OP_BYTE, CH_DOT);
      repeat ($urandom_range(0, 4)) send_item(OP_BYTE, 8'("0" + $urandom_range(0, 9)));
    end
  endtask

  // Keywords, most spelled right and some slightly off.
  task automatic send_keyword();
    string s;
    s = keyword_words[$urandom_range(0, 5)];
    case ($urandom_range(0, 7))
      0: s = s.substr(0, s.len() - 2);
      1: s[0] = s[0] - 8'd32;
      2: s = {s, "s"};
      default: ;
    endcase
    send_text(s);
  endtask

  task automatic send_random_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      send_keyword();
    end else if (r < 40) begin
      repeat (($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 9))
        send_item(OP_BYTE, random_letter());
    end else if (r < 60) begin
      send_number();
    end else if (r < 80) begin
      send_item(OP_BYTE, punct_chars[$urandom_range(0, 9)]);
    end else if (r < 88) begin
      send_item(OP_BYTE, random_stray());
    end else begin
      send_item(OP_BYTE, CH_MINUS);
    end
  endtask

  task automatic send_source_line();
    repeat ($urandom_range(4, 30)) begin
      send_random_token();
      if ($urandom_range(0, 9) < 6) send_item(OP_BYTE, random_space());
    end
    if ($urandom_range(0, 19) != 0) send_eot();
  endtask

  // Every punctuation mark, a null byte and end of text.
  task automatic test_punctuation();
    send_text("{(),;=+*/}");
    send_item(OP_BYTE, 8'h00);
    send_item(OP_EOT, 8'h00);
  endtask

  // Signed float ended by a minus, lone minus, a high byte after an identifier,
  // and a second dot after a float.
  task automatic test_numbers_and_minus();
    send_text("-9.5-x");
    send_item(OP_BYTE, 8'h80);
    send_text("1.2.");
    send_item(OP_EOT, 8'hFF);
  endtask

  // Keywords ended by a tab and by a minus, a float without fraction digits
  // ended by an unknown byte, and a minus flushed by end of text.
  task automatic test_keywords_and_unknown();
    send_text("if");
    send_item(OP_BYTE, 8'h09);
    send_text("7.");
    send_item(OP_BYTE, 8'hFF);
    send_text(" return-");
    send_eot();
  endtask

  // Tokens longer than one byte's worth of length.
  task automatic test_long_tokens();
    repeat (260) send_item(OP_BYTE, 8'("0" + $urandom_range(0, 9)));
    send_item(OP_BYTE, ";");
    repeat (260) send_item(OP_BYTE, random_letter());
    send_eot();
  endtask

  // Source-like lines with random content, with one full drain midway.
  task automatic test_random_source(input int target);
    int  stop_at;
    bit  paused;
    stop_at = items_sent + target;
    paused  = 1'b0;
    while (items_sent < stop_at) begin
      calm = ($urandom_range(0, 4) == 0);
      send_source_line();
      if (!paused && items_sent >= stop_at - target / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end
    calm = 1'b0;
  endtask

  // Arbitrary bytes with occasional end of text.
  task automatic test_random_noise(input int count);
    repeat (count) begin
      if ($urandom_range(0, 29) == 0) send_eot();
      else send_item(OP_BYTE, 8'($urandom_range(0, 255)));
    end
    send_eot();
  endtask

  // Main sequence.
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    calm        = 1'b0;
    stall_left  = 0;
    error_count = 0;
    items_sent  = 0;
    text_bytes  = 0;
    eot_items   = 0;
    tokens_seen = 0;
    clear_scanner();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_punctuation();
    test_numbers_and_minus();
    test_keywords_and_unknown();
    test_long_tokens();
    test_random_source(650);
    test_random_noise(300);

    hold_until_drained();
    repeat (8) @(posedge clk);

    $display("Run covered %0d text bytes and %0d end-of-text transactions, %0d tokens checked.",
             text_bytes, eot_items, tokens_seen);
    $display("Directed punctuation, numbers, keywords, stray bytes and long tokens, then random lines and noise.");
    if (error_count == 0 && expected_tokens.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d tokens still expected", error_count,
               expected_tokens.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20ms;
    $display("Timeout with %0d tokens still expected", expected_tokens.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
